@@ hdl/fbt_pkg.sv @@
// ----------------------------------------------------------------------------
// fbt_pkg: shared types and constants of the frame batcher
// Word layouts of both channels, operation and status codes, the batch
// geometry and the byte helpers used to build records and packets.
// ----------------------------------------------------------------------------
package fbt_pkg;

  // Batch geometry
  localparam int RECORDS_PER_BATCH = 4;
  localparam int RECORD_BYTES      = 16;
  localparam int PACKET_BYTES      = 64;
  localparam int STORE_BYTES       = 64;
  localparam int STORE_WORDS       = STORE_BYTES / 8;
  localparam int PACKET_BEATS      = (PACKET_BYTES + 7) / 8;
  localparam int NB_W              = 10;
  localparam int RB_W              = 7;
  localparam int CNT_W             =
    $clog2((STORE_WORDS > PACKET_BEATS ? STORE_WORDS : PACKET_BEATS) + 1);
  localparam logic [NB_W-1:0] NB_BATCH = NB_W'(RECORDS_PER_BATCH * RECORD_BYTES);

  // Operation codes
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_DATA  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_DROP  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [28:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] packet_word;
    logic [2:0]  beat_index;
    logic        last_beat;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       frame_wr;
    logic       tick;
    logic       drain_ring;
    logic       drain_flush;
    logic       push_wr;
    logic       rd_en;
    logic [2:0] word_idx;
    logic       from_flush;
    logic       out_load;
    logic       out_rpt;
    logic [1:0] rpt_status;
    logic [2:0] beat;
    logic       last;
  } fbt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic ring_empty;
    logic ring_full;
    logic batch_done;
    logic flush_ok;
    logic out_free;
  } fbt_stat_t;

  // Byte k of a record built from one received frame
  function automatic logic [7:0] rec_byte(input logic [RB_W-1:0] k,
                                          input logic [28:0] id,
                                          input logic [3:0] len,
                                          input logic [63:0] data);
    logic [31:0] id32;
    id32 = {3'b000, id};
    rec_byte = 8'h00;
    if (k < RB_W'(4))
      rec_byte = id32[{k[1:0], 3'b000} +: 8];
    else if (k == RB_W'(4))
      rec_byte = {4'h0, len};
    else if (k >= RB_W'(8) && k < RB_W'(16))
      rec_byte = data[{k[2:0], 3'b000} +: 8];
  endfunction

  // Byte mask of one packet word: keep bytes below nbytes and the packet size
  function automatic logic [63:0] word_mask(input logic [2:0] widx,
                                            input logic [NB_W-1:0] nbytes);
    logic [NB_W-1:0] off;
    word_mask = '0;
    for (int b = 0; b < 8; b++) begin
      off = NB_W'({widx, 3'(b)});
      if (off < nbytes && off < NB_W'(PACKET_BYTES))
        word_mask[b*8 +: 8] = 8'hFF;
    end
  endfunction

endpackage

@@ hdl/fbt_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbt_ctrl: sequencing controller of the frame batcher
// Decodes accepted words, steps the batch copy into the ring memory and the
// beat-by-beat drain, and schedules single status results.
// ----------------------------------------------------------------------------
module fbt_ctrl
  import fbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  input  fbt_stat_t st,
  output fbt_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_PUSH, S_DRAIN, S_REPORT} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       load_r, load_nxt;
  logic             rdv_r, rdv_nxt;
  logic             flush_r, flush_nxt;
  logic [1:0]       rpt_r, rpt_nxt;

  // Take a new word only when no work is pending
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    load_nxt       = load_r;
    rdv_nxt        = rdv_r;
    flush_nxt      = flush_r;
    rpt_nxt        = rpt_r;
    cmd            = '0;
    cmd.word_idx   = cnt_r[2:0];
    cmd.from_flush = flush_r;
    cmd.beat       = load_r;
    cmd.last       = (load_r == 3'(PACKET_BEATS - 1));
    cmd.rpt_status = rpt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt  = '0;
          load_nxt = '0;
          rdv_nxt  = 1'b0;
          unique case (in_data.op)
            OP_FRAME: begin
              cmd.frame_wr = 1'b1;
              if (st.batch_done) begin
                if (st.ring_full) begin
                  rpt_nxt   = STATUS_DROP;
                  state_nxt = S_REPORT;
                end else begin
                  state_nxt = S_PUSH;
                end
              end
            end
            OP_TICK: cmd.tick = 1'b1;
            OP_DRAIN: begin
              if (!st.ring_empty) begin
                cmd.drain_ring = 1'b1;
                flush_nxt      = 1'b0;
                state_nxt      = S_DRAIN;
              end else if (st.flush_ok) begin
                cmd.drain_flush = 1'b1;
                flush_nxt       = 1'b1;
                state_nxt       = S_DRAIN;
              end else begin
                rpt_nxt   = STATUS_EMPTY;
                state_nxt = S_REPORT;
              end
            end
            default: ;
          endcase
        end
      end
      S_PUSH: begin
        // copy one batch word into the newest ring slot
        cmd.push_wr = 1'b1;
        cnt_nxt     = cnt_r + CNT_W'(1);
        if (cnt_r[2:0] == 3'(STORE_WORDS - 1))
          state_nxt = S_IDLE;
      end
      S_DRAIN: begin
        // read one word ahead, load it once the output register frees up
        cmd.out_load = rdv_r && st.out_free;
        cmd.rd_en    = (cnt_r < CNT_W'(PACKET_BEATS)) && (!rdv_r || cmd.out_load);
        if (cmd.rd_en)
          cnt_nxt = cnt_r + CNT_W'(1);
        rdv_nxt = cmd.rd_en || (rdv_r && !cmd.out_load);
        if (cmd.out_load) begin
          load_nxt = load_r + 3'd1;
          if (cmd.last)
            state_nxt = S_IDLE;
        end
      end
      S_REPORT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_rpt  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and sequencing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      load_r  <= '0;
      rdv_r   <= 1'b0;
      flush_r <= 1'b0;
      rpt_r   <= STATUS_EMPTY;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      load_r  <= load_nxt;
      rdv_r   <= rdv_nxt;
      flush_r <= flush_nxt;
      rpt_r   <= rpt_nxt;
    end
  end

endmodule

@@ hdl/fbt_dpath.sv @@
// ----------------------------------------------------------------------------
// fbt_dpath: datapath of the frame batcher
// Batch store, ring memory with head and tail pointers, record and tick
// counters, timeout register and the output register.
// ----------------------------------------------------------------------------
module fbt_dpath
  import fbt_pkg::*;
#(
  parameter int RING_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  fbt_cmd_t  cmd,
  output fbt_stat_t st,
  input  logic      cfg_valid,
  input  logic [15:0] cfg_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int PTR_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int ADDR_W = PTR_W + 3;

  logic [63:0]       store_r   [STORE_WORDS];
  logic [63:0]       store_nxt [STORE_WORDS];
  logic [63:0]       ring_mem  [RING_SLOTS * 8];
  logic [63:0]       ring_rdata_r;
  logic [63:0]       flush_word_r;
  logic [63:0]       store_word;
  logic [2:0]        rc_r;
  logic [2:0]        flush_rc_r;
  logic [3:0]        rc_inc;
  logic [15:0]       tick_r;
  logic              run_r;
  logic [15:0]       timeout_r;
  logic [PTR_W-1:0]  head_r, tail_r, head_next, tail_next;
  logic [NB_W-1:0]   rec_base;
  logic [NB_W-1:0]   flush_nb;
  logic              out_valid_r;
  out_item_t         out_data_r;

  // Advance a ring pointer with wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_SLOTS - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head_next     = ptr_inc(head_r);
  assign tail_next     = ptr_inc(tail_r);
  assign rc_inc        = {1'b0, rc_r} + 4'd1;
  assign st.ring_empty = (head_r == tail_r);
  assign st.ring_full  = (tail_next == head_r);
  assign st.batch_done = (rc_inc >= 4'(RECORDS_PER_BATCH));
  assign st.flush_ok   = (tick_r > timeout_r) && (rc_r != 3'd0);
  assign st.out_free   = !out_valid_r || !out_stall;
  assign rec_base      = NB_W'(rc_r) * NB_W'(RECORD_BYTES);
  assign flush_nb      = NB_W'(flush_rc_r) * NB_W'(RECORD_BYTES);
  assign store_word    = store_r[cmd.word_idx];

  // Place the received frame as a record at its slot of the batch
  always_comb begin
    store_nxt = store_r;
    for (int off = 0; off < STORE_BYTES; off++) begin
      if (NB_W'(off) >= rec_base && NB_W'(off) < rec_base + NB_W'(RECORD_BYTES) &&
          off < PACKET_BYTES)
        store_nxt[off >> 3][(off & 7) * 8 +: 8] =
          rec_byte(RB_W'(NB_W'(off) - rec_base), in_data.frame_id,
                   in_data.frame_length, in_data.frame_data);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_wr)
      store_r <= store_nxt;
  end

  // Ring memory: write batch words, read packet words
  always_ff @(posedge clk) begin
    if (cmd.push_wr)
      ring_mem[ADDR_W'({tail_r, cmd.word_idx})] <= store_word & word_mask(cmd.word_idx, NB_BATCH);
    if (cmd.rd_en)
      ring_rdata_r <= ring_mem[ADDR_W'({head_r, cmd.word_idx})];
  end

  // Fetch a zero-padded word of the partial batch
  always_ff @(posedge clk) begin
    if (cmd.rd_en)
      flush_word_r <= store_word & word_mask(cmd.word_idx, flush_nb);
  end

  // Counters, pointers, timer and timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r       <= '0;
      flush_rc_r <= '0;
      tick_r     <= '0;
      run_r      <= 1'b0;
      head_r     <= '0;
      tail_r     <= '0;
      timeout_r  <= 16'd10;
    end else begin
      if (cfg_valid)
        timeout_r <= cfg_data;
      if (cmd.frame_wr) begin
        rc_r <= st.batch_done ? 3'd0 : rc_inc[2:0];
        if (rc_r == 3'd0) begin
          tick_r <= '0;
          run_r  <= 1'b1;
        end
        if (st.batch_done && !st.ring_full)
          tail_r <= tail_next;
      end
      if (cmd.tick && run_r && tick_r != 16'hFFFF)
        tick_r <= tick_r + 16'd1;
      if (cmd.drain_ring) begin
        run_r  <= 1'b0;
        head_r <= head_next;
      end
      if (cmd.drain_flush) begin
        run_r      <= 1'b0;
        flush_rc_r <= rc_r;
        rc_r       <= '0;
      end
    end
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_rpt) begin
        out_data_r <= '{status: cmd.rpt_status, packet_word: 64'd0,
                        beat_index: 3'd0, last_beat: 1'b1};
      end else begin
        out_data_r <= '{status: STATUS_DATA,
                        packet_word: cmd.from_flush ? flush_word_r : ring_rdata_r,
                        beat_index: cmd.beat, last_beat: cmd.last};
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/frame_batcher_with_timeout_flush.sv @@
// ----------------------------------------------------------------------------
// frame_batcher_with_timeout_flush: top level of the frame batcher
// Packs received frames into records, batches them into packets held in a
// ring memory and drains packets, or a timed-out partial batch, as beats.
// ----------------------------------------------------------------------------
// A tick word, or a frame that leaves a batch incomplete, keeps the controller
// idle. A frame completing a batch has it copied into the ring memory one
// 64-bit word per cycle through its single write port. A drain that sends data
// reads the ring memory (or the batch store) one beat per cycle ahead of the
// output register while the output does not stall. A status result reports an
// empty ring or a dropped batch. Output stalls lengthen a drain beat by beat;
// a new word is taken as soon as the last result sits in the output register.
// The timeout register may be written at any cycle (cfg_ready is always high).
// RING_SLOTS - 1 packets of 64 bytes are held, one slot always free.
module frame_batcher_with_timeout_flush
  import fbt_pkg::*;
#(
  parameter int RING_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  fbt_cmd_t  cmd;
  fbt_stat_t st;

  assign cfg_ready = 1'b1;

  fbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  fbt_dpath #(
    .RING_SLOTS (RING_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hdl/fbt_checker.sv @@
// ----------------------------------------------------------------------------
// fbt_checker: port-level checks of the frame batcher
// Watches the result channel and drain handling over time; bound to the top.
// ----------------------------------------------------------------------------
module fbt_checker
  import fbt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Status results are single zero words marked last
  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_DATA |->
      out_data.last_beat && out_data.beat_index == 3'd0 && out_data.packet_word == 64'd0)
    else $error("malformed status result");

  // Mark exactly the final beat of a packet as last
  a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_DATA |->
      out_data.last_beat == (out_data.beat_index == 3'(PACKET_BEATS - 1)))
    else $error("last beat flag does not match beat index");

  // A drain always produces a result, so the input is held off next cycle
  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.op == OP_DRAIN |=> in_stall)
    else $error("drain accepted without producing a result");

endmodule

bind frame_batcher_with_timeout_flush fbt_checker u_fbt_checker (.*);
